// ----- rtl/bm25_pkg.sv -----
`timescale 1ns / 1ps

package bm25_pkg;

   // Command codes carried by the request channel.
   localparam logic [1:0] CMD_LOAD     = 2'd0;
   localparam logic [1:0] CMD_POSTING  = 2'd1;
   localparam logic [1:0] CMD_BEGIN    = 2'd2;
   localparam logic [1:0] CMD_RESERVED = 2'd3;

   // Register map of the control port.
   localparam int unsigned CSR_INDEX_W = 8;
   localparam int unsigned CSR_DATA_W  = 24;
   localparam logic [CSR_INDEX_W-1:0] REG_K1_GAIN       = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PRE_SCALE     = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_SCORE_SCALE   = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_POSTING_LIMIT = 8'd3;

   // Register values after reset.
   localparam logic [15:0] K1_GAIN_RESET       = 16'd4915;
   localparam logic [15:0] PRE_SCALE_RESET     = 16'd256;
   localparam logic [23:0] SCORE_SCALE_RESET   = 24'd65536;
   localparam logic [16:0] POSTING_LIMIT_RESET = 17'd65536;

   // Docid and posting counter limits, and one in Q4.12.
   localparam logic [16:0] DOCID_ONES = 17'h1FFFF;
   localparam logic [16:0] COUNT_MAX  = 17'h1FFFF;
   localparam logic [16:0] K1_ONE     = 17'd4096;

   // Job queue between the front and back ends.
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = 2;

   // One unit of work for the back end: a table load or a posting to score.
   typedef struct packed {
      logic        is_load;
      logic [15:0] table_index;
      logic [31:0] prior_value;
      logic [15:0] doc_number;
      logic        out_of_range;
      logic [7:0]  tf;
   } job_type;

   // Scoring coefficients held by the control registers.
   typedef struct packed {
      logic [15:0] k1_gain;
      logic [15:0] pre_scale;
      logic [23:0] score_scale;
   } coef_type;

endpackage

// ----- rtl/bm25_req_if.sv -----
`timescale 1ns / 1ps

interface bm25_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [15:0] table_index;
   logic [31:0] prior_value;
   logic [15:0] posting_word;

   modport source (output valid, cmd, table_index, prior_value, posting_word, input ready);
   modport sink (input valid, cmd, table_index, prior_value, posting_word, output ready);
endinterface

// ----- rtl/bm25_rsp_if.sv -----
`timescale 1ns / 1ps

interface bm25_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] doc_number;
   logic [31:0] score;
   logic        out_of_range;

   modport source (output valid, doc_number, score, out_of_range, input ready);
   modport sink (input valid, doc_number, score, out_of_range, output ready);
endinterface

// ----- rtl/bm25_csr_if.sv -----
`timescale 1ns / 1ps

interface bm25_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  index;
   logic [23:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/bm25_front.sv -----
`timescale 1ns / 1ps

module bm25_front #(
   parameter int unsigned DOC_COUNT = 65536
) (
   input  logic              clock,
   input  logic              reset,
   bm25_req_if.sink          req_ch,
   input  logic [16:0]       posting_limit,
   output logic              push_valid,
   input  logic              push_ready,
   output bm25_pkg::job_type push_job
);
   import bm25_pkg::*;

   localparam int unsigned TABLE_DEPTH = (DOC_COUNT < 65536) ? DOC_COUNT : 65536;

   logic [16:0] running_docid_ff, running_docid_in;
   logic [7:0]  group_tf_ff, group_tf_in;
   logic        expect_impact_ff, expect_impact_in;
   logic [16:0] postings_done_ff, postings_done_in;
   logic        term_finished_ff, term_finished_in;

   logic        accept;
   logic [17:0] gap_sum;
   logic [16:0] next_docid;

   assign req_ch.ready = push_ready;
   assign accept       = req_ch.valid && push_ready;

   // Docid advance; saturates at all ones unless it starts from all ones.
   assign gap_sum = {1'b0, running_docid_ff} + {2'b00, req_ch.posting_word};
   always_comb begin
      if (running_docid_ff != DOCID_ONES && gap_sum[17]) begin
         next_docid = DOCID_ONES;
      end else begin
         next_docid = gap_sum[16:0];
      end
   end

   // Classify the item and update the term state.
   always_comb begin
      running_docid_in = running_docid_ff;
      group_tf_in      = group_tf_ff;
      expect_impact_in = expect_impact_ff;
      postings_done_in = postings_done_ff;
      term_finished_in = term_finished_ff;
      push_valid       = 1'b0;
      push_job.is_load      = 1'b0;
      push_job.table_index  = req_ch.table_index;
      push_job.prior_value  = req_ch.prior_value;
      push_job.doc_number   = next_docid[15:0];
      push_job.out_of_range = 32'(next_docid) >= TABLE_DEPTH;
      push_job.tf           = group_tf_ff;
      if (accept) begin
         case (req_ch.cmd)
            CMD_LOAD: begin
               push_job.is_load = 1'b1;
               push_valid       = 32'(req_ch.table_index) < TABLE_DEPTH;
            end
            CMD_BEGIN: begin
               running_docid_in = DOCID_ONES;
               group_tf_in      = '0;
               expect_impact_in = 1'b1;
               postings_done_in = '0;
               term_finished_in = 1'b0;
            end
            CMD_POSTING: begin
               if (!term_finished_ff) begin
                  if (expect_impact_ff) begin
                     if (postings_done_ff < posting_limit) begin
                        group_tf_in = (req_ch.posting_word > 16'd255) ?
                                      8'hFF : req_ch.posting_word[7:0];
                        running_docid_in = DOCID_ONES;
                        expect_impact_in = 1'b0;
                     end else begin
                        term_finished_in = 1'b1;
                     end
                  end else if (req_ch.posting_word == '0) begin
                     expect_impact_in = 1'b1;
                  end else begin
                     running_docid_in = next_docid;
                     if (postings_done_ff < COUNT_MAX) begin
                        postings_done_in = postings_done_ff + 17'd1;
                     end
                     push_valid = 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_docid_ff <= DOCID_ONES;
         group_tf_ff      <= '0;
         expect_impact_ff <= 1'b1;
         postings_done_ff <= '0;
         term_finished_ff <= 1'b0;
      end else begin
         running_docid_ff <= running_docid_in;
         group_tf_ff      <= group_tf_in;
         expect_impact_ff <= expect_impact_in;
         postings_done_ff <= postings_done_in;
         term_finished_ff <= term_finished_in;
      end
   end

endmodule

// ----- rtl/bm25_queue.sv -----
`timescale 1ns / 1ps

module bm25_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  bm25_pkg::job_type push_job,
   output logic              pop_valid,
   input  logic              pop,
   output bm25_pkg::job_type pop_job
);
   import bm25_pkg::*;

   job_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_PTR_W:0]   count_ff;
   logic                   do_push, do_pop;

   assign push_ready = count_ff != QUEUE_PTR_W'(0) + (QUEUE_PTR_W+1)'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_job    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   // Pointer and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + (QUEUE_PTR_W+1)'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - (QUEUE_PTR_W+1)'(1);
         end
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ----- rtl/bm25_back.sv -----
`timescale 1ns / 1ps

module bm25_back #(
   parameter int unsigned DOC_COUNT = 65536
) (
   input  logic               clock,
   input  logic               reset,
   input  bm25_pkg::coef_type coef,
   input  logic               pop_valid,
   output logic               pop,
   input  bm25_pkg::job_type  pop_job,
   bm25_rsp_if.source         rsp_ch
);
   import bm25_pkg::*;

   localparam int unsigned TABLE_DEPTH = (DOC_COUNT < 65536) ? DOC_COUNT : 65536;
   localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);

   typedef enum logic [2:0] {
      ST_IDLE, ST_SETUP, ST_DIVIDE, ST_GAIN, ST_LOW, ST_HIGH, ST_SUM, ST_EMIT
   } state_type;

   state_type   state_ff, state_in;
   logic [23:0] pt_ff, pt_in;
   logic [32:0] den_ff, den_in;
   logic [32:0] rem_ff, rem_in;
   logic [32:0] quo_ff, quo_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [37:0] t_ff, t_in;
   logic [42:0] plo_ff, plo_in;
   logic [42:0] phi_ff, phi_in;
   logic [15:0] doc_ff, doc_in;
   logic        oor_ff, oor_in;
   logic [31:0] res_ff, res_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] out_doc_ff, out_doc_in;
   logic [31:0] out_score_ff, out_score_in;
   logic        out_oor_ff, out_oor_in;

   logic [31:0] prior_mem [TABLE_DEPTH];
   logic [31:0] prior_rd_ff;
   logic        mem_we;

   logic [33:0] rem_shift;
   logic [49:0] gain_prod;
   logic [61:0] score_sum;
   logic        out_free;

   assign rem_shift = {rem_ff, 1'b0};
   assign gain_prod = quo_ff * ({1'b0, coef.k1_gain} + K1_ONE);
   assign score_sum = {phi_ff, 19'b0} + {19'b0, plo_ff};
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign mem_we    = state_ff == ST_IDLE && pop_valid && pop_job.is_load;

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.doc_number   = out_doc_ff;
   assign rsp_ch.score        = out_score_ff;
   assign rsp_ch.out_of_range = out_oor_ff;

   // Prior table; the head job's docid is read every cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         prior_mem[pop_job.table_index[ADDR_W-1:0]] <= pop_job.prior_value;
      end
      prior_rd_ff <= prior_mem[pop_job.doc_number[ADDR_W-1:0]];
   end

   // Scoring sequencer: divide bit by bit, then a gain and two scale multiplies.
   always_comb begin
      state_in     = state_ff;
      pt_in        = pt_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      t_in         = t_ff;
      plo_in       = plo_ff;
      phi_in       = phi_ff;
      doc_in       = doc_ff;
      oor_in       = oor_ff;
      res_in       = res_ff;
      out_doc_in   = out_doc_ff;
      out_score_in = out_score_ff;
      out_oor_in   = out_oor_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      pop          = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               pop = 1'b1;
               if (!pop_job.is_load) begin
                  doc_in = pop_job.doc_number;
                  oor_in = pop_job.out_of_range;
                  pt_in  = coef.pre_scale * pop_job.tf;
                  res_in = '0;
                  state_in = pop_job.out_of_range ? ST_EMIT : ST_SETUP;
               end
            end
         end
         ST_SETUP: begin
            den_in = {1'b0, pt_ff, 8'b0} + {1'b0, prior_rd_ff};
            rem_in = {2'b00, pt_ff, 7'b0};
            quo_in = '0;
            cnt_in = '0;
            state_in = (({1'b0, pt_ff, 8'b0} + {1'b0, prior_rd_ff}) == '0) ?
                       ST_GAIN : ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (rem_shift >= {1'b0, den_ff}) begin
               rem_in = 33'(rem_shift - {1'b0, den_ff});
               quo_in = {quo_ff[31:0], 1'b1};
            end else begin
               rem_in = rem_shift[32:0];
               quo_in = {quo_ff[31:0], 1'b0};
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd32) begin
               state_in = ST_GAIN;
            end
         end
         ST_GAIN: begin
            t_in     = gain_prod[49:12];
            state_in = ST_LOW;
         end
         ST_LOW: begin
            plo_in   = t_ff[18:0] * coef.score_scale;
            state_in = ST_HIGH;
         end
         ST_HIGH: begin
            phi_in   = t_ff[37:19] * coef.score_scale;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            res_in   = {2'b00, score_sum[61:32]};
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               out_doc_in   = doc_ff;
               out_score_in = res_ff;
               out_oor_in   = oor_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pt_ff        <= pt_in;
      den_ff       <= den_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      cnt_ff       <= cnt_in;
      t_ff         <= t_in;
      plo_ff       <= plo_in;
      phi_ff       <= phi_in;
      doc_ff       <= doc_in;
      oor_ff       <= oor_in;
      res_ff       <= res_in;
      out_doc_ff   <= out_doc_in;
      out_score_ff <= out_score_in;
      out_oor_ff   <= out_oor_in;
   end

   // A docid beyond the table always reports a zero score.
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && out_oor_ff |-> out_score_ff == '0)
      else $error("out-of-range result with nonzero score");

   // The divider never runs past its last quotient bit.
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIVIDE |-> cnt_ff <= 6'd32)
      else $error("divider step count overran");

   // A finished score moves into the output register once it is free.
   a_emit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT && out_free |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("finished score was not presented");

endmodule

// ----- rtl/bm25_impact_postings_scorer_core.sv -----
`timescale 1ns / 1ps

// BM25 scorer for one term's impact-ordered postings list. Load the prior
// table with load commands, send a begin-term command, then stream posting
// words; each docid gap returns one result with its docid and Q16.16 score.
// The front end takes one request per cycle as long as its four-entry job
// queue has room; words that give no result never reach the queue. Each
// scored posting holds the back end through setup, the 33-step bit-serial
// divider, three multiply stages and a sum before it takes the next job; a
// posting beyond the table goes straight to emit. Control registers may be
// written only while the block is idle. The control port is always ready.
module bm25_impact_postings_scorer_core #(
   parameter int unsigned DOC_COUNT = 65536
) (
   input  logic       clock,
   input  logic       reset,
   bm25_req_if.sink   req_ch,
   bm25_rsp_if.source rsp_ch,
   bm25_csr_if.sink   csr_ch
);
   import bm25_pkg::*;

   logic [15:0] k1_gain_ff;
   logic [15:0] pre_scale_ff;
   logic [23:0] score_scale_ff;
   logic [16:0] posting_limit_ff;

   coef_type coef;
   job_type  push_job, pop_job;
   logic     push_valid, push_ready, pop_valid, pop;

   assign csr_ch.ready = 1'b1;
   assign coef.k1_gain     = k1_gain_ff;
   assign coef.pre_scale   = pre_scale_ff;
   assign coef.score_scale = score_scale_ff;

   // Control register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         k1_gain_ff       <= K1_GAIN_RESET;
         pre_scale_ff     <= PRE_SCALE_RESET;
         score_scale_ff   <= SCORE_SCALE_RESET;
         posting_limit_ff <= POSTING_LIMIT_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            REG_K1_GAIN:       k1_gain_ff       <= csr_ch.data[15:0];
            REG_PRE_SCALE:     pre_scale_ff     <= csr_ch.data[15:0];
            REG_SCORE_SCALE:   score_scale_ff   <= csr_ch.data;
            REG_POSTING_LIMIT: posting_limit_ff <= csr_ch.data[16:0];
            default: begin
            end
         endcase
      end
   end

   bm25_front #(.DOC_COUNT(DOC_COUNT)) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .posting_limit (posting_limit_ff),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_job      (push_job)
   );

   bm25_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_job    (pop_job)
   );

   bm25_back #(.DOC_COUNT(DOC_COUNT)) u_back (
      .clock     (clock),
      .reset     (reset),
      .coef      (coef),
      .pop_valid (pop_valid),
      .pop       (pop),
      .pop_job   (pop_job),
      .rsp_ch    (rsp_ch)
   );

endmodule
